### rtl/rankine_vortex_radial_velocity_assert.svh
// Assertion macros shared by the RTL of the vortex velocity block.
// Define ASSERT_OFF to compile every assertion away.
`ifndef RANKINE_VORTEX_RADIAL_VELOCITY_ASSERT_SVH
`define RANKINE_VORTEX_RADIAL_VELOCITY_ASSERT_SVH
`ifndef ASSERT_OFF
`define RVRV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rvrv assertion failed");
`define RVRV_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rvrv assertion failed");
`else
`define RVRV_ASSERT(lbl, clk, rst_n, prop)
`define RVRV_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### rtl/rvrv_pkg.sv
`timescale 1ns / 1ps
package rvrv_pkg;

  localparam int unsigned AZ_W    = 9;
  localparam int unsigned RK_W    = 9;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned RV_W    = 17;

  localparam int unsigned CORDIC_STEPS = 17;

  // Angles in 1/16 degree.
  localparam logic [13:0] TURN16    = 14'd5760;
  localparam logic [13:0] QUART16   = 14'd1440;
  localparam logic [13:0] THREEQ16  = 14'd4320;
  localparam logic signed [14:0] HALF16_S = 15'sd2880;
  localparam logic signed [14:0] TURN16_S = 15'sd5760;

  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // Arctangent of 2^-i in 1/65536 degree.
  localparam logic signed [24:0] ATAN_DEG16 [CORDIC_STEPS] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
    25'sd117304, 25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334, 25'sd3667,
    25'sd1833, 25'sd917, 25'sd458, 25'sd229, 25'sd115, 25'sd57
  };

  localparam logic [POS_W-1:0]   CENTER_AZIMUTH_RST  = 13'd0;
  localparam logic [POS_W-1:0]   CENTER_RANGE_RST    = 13'd0;
  localparam logic [POS_W-1:0]   MAX_WIND_RADIUS_RST = 13'd160;
  localparam logic [SPEED_W-1:0] MAX_WIND_SPEED_RST  = 8'd50;

  typedef enum logic [1:0] {
    REG_CENTER_AZIMUTH  = 2'd0,
    REG_CENTER_RANGE    = 2'd1,
    REG_MAX_WIND_RADIUS = 2'd2,
    REG_MAX_WIND_SPEED  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic              flip;
    logic signed [24:0] z;
  } ang_t;

  // Two rotation lanes: beam (b) and vortex center (c).
  typedef struct packed {
    logic signed [32:0] xb;
    logic signed [32:0] yb;
    logic signed [24:0] zb;
    logic               flb;
    logic signed [32:0] xc;
    logic signed [32:0] yc;
    logic signed [24:0] zc;
    logic               flc;
    logic [RK_W-1:0]    rk;
    logic               zero;
  } cord_t;

  typedef struct packed {
    logic [RK_W-1:0] rk;
    logic            zero;
    logic            neg;
    logic            in_core;
  } side_t;

  typedef struct packed {
    logic [61:0] num;
    logic [61:0] res;
  } sq62_t;

  typedef struct packed {
    logic [33:0] num;
    logic [33:0] res;
  } sq34_t;

  typedef struct packed {
    logic [63:0] rem_a;
    logic [30:0] den_a;
    logic [32:0] q_a;
    logic [63:0] rem_b;
    logic [30:0] den_b;
    logic [32:0] q_b;
  } dvab_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [35:0] q;
  } divc_t;

  // Folds an angle into [-90, 90] degrees and scales it to 1/65536 degree.
  function automatic ang_t prep_angle(logic [12:0] ang);
    logic [13:0]        a;
    logic signed [14:0] s;
    ang_t               o;
    a = ({1'b0, ang} >= TURN16) ? ({1'b0, ang} - TURN16) : {1'b0, ang};
    o.flip = 1'b0;
    if (a > QUART16 && a < THREEQ16) begin
      s = $signed({1'b0, a}) - HALF16_S;
      o.flip = 1'b1;
    end else if (a >= THREEQ16) begin
      s = $signed({1'b0, a}) - TURN16_S;
    end else begin
      s = $signed({1'b0, a});
    end
    o.z = 25'(s) <<< 12;
    return o;
  endfunction

  function automatic cord_t cordic_iter(cord_t c, int unsigned i);
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    cord_t              o;
    o = c;
    xs = c.xb >>> i;
    ys = c.yb >>> i;
    if (c.zb >= 0) begin
      o.xb = c.xb - ys;
      o.yb = c.yb + xs;
      o.zb = c.zb - ATAN_DEG16[i];
    end else begin
      o.xb = c.xb + ys;
      o.yb = c.yb - xs;
      o.zb = c.zb + ATAN_DEG16[i];
    end
    xs = c.xc >>> i;
    ys = c.yc >>> i;
    if (c.zc >= 0) begin
      o.xc = c.xc - ys;
      o.yc = c.yc + xs;
      o.zc = c.zc - ATAN_DEG16[i];
    end else begin
      o.xc = c.xc + ys;
      o.yc = c.yc - xs;
      o.zc = c.zc + ATAN_DEG16[i];
    end
    return o;
  endfunction

endpackage

### rtl/rvrv_in_if.sv
`timescale 1ns / 1ps
interface rvrv_in_if;
  import rvrv_pkg::*;
  logic            valid;
  logic            ready;
  logic [AZ_W-1:0] azimuth_deg;
  logic [RK_W-1:0] range_km;
  modport source (output valid, azimuth_deg, range_km, input ready);
  modport sink (input valid, azimuth_deg, range_km, output ready);
endinterface

### rtl/rvrv_out_if.sv
`timescale 1ns / 1ps
interface rvrv_out_if;
  import rvrv_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [RV_W-1:0] radial_velocity;
  modport source (output valid, radial_velocity, input ready);
  modport sink (input valid, radial_velocity, output ready);
endinterface

### rtl/rankine_vortex_radial_velocity.sv
// Channel  | Dir | Handshake     | Beat payload
// in_i     | in  | valid/ready   | azimuth_deg[8:0], range_km[8:0]
// out_o    | out | valid/ready   | radial_velocity[16:0] signed, 1/256 m/s
// apb      | in  | psel/penable  | paddr[3:2] register index, pwdata, prdata
//
// One beat enters per cycle while the output is not held; the depth is
// set by the bit-per-stage square roots and dividers that follow the CORDIC.
// rst_ni clears every stage valid bit and loads the register reset values.
// A held output stalls the whole pipeline in place; nothing is dropped or
// repeated, and in_i.ready returns as soon as the output beat is taken.
`timescale 1ns / 1ps
`include "rankine_vortex_radial_velocity_assert.svh"
module rankine_vortex_radial_velocity #(
  parameter int unsigned AZIMUTH_STEPS = 360,
  parameter int unsigned RANGE_GATES   = 400
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rvrv_in_if.sink           in_i,
  rvrv_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rvrv_pkg::*;

  // Stage counts of the iterative units.
  localparam int unsigned CS   = CORDIC_STEPS;
  localparam int unsigned SQ_N = 31;
  localparam int unsigned DV_N = 33;
  localparam int unsigned S2_N = 17;
  localparam int unsigned DC_N = 36;

  // Configuration registers, read directly by every stage. The user must only change
  // them while the pipeline is empty; the block itself does not enforce this.
  logic [POS_W-1:0]   ca_q, cr_q, mwr_q;
  logic [SPEED_W-1:0] mws_q;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q  <= CENTER_AZIMUTH_RST;
      cr_q  <= CENTER_RANGE_RST;
      mwr_q <= MAX_WIND_RADIUS_RST;
      mws_q <= MAX_WIND_SPEED_RST;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_CENTER_AZIMUTH:  ca_q  <= pwdata[POS_W-1:0];
        REG_CENTER_RANGE:    cr_q  <= pwdata[POS_W-1:0];
        REG_MAX_WIND_RADIUS: mwr_q <= pwdata[POS_W-1:0];
        REG_MAX_WIND_SPEED:  mws_q <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_CENTER_AZIMUTH:  prdata = 32'(ca_q);
      REG_CENTER_RANGE:    prdata = 32'(cr_q);
      REG_MAX_WIND_RADIUS: prdata = 32'(mwr_q);
      REG_MAX_WIND_SPEED:  prdata = 32'(mws_q);
      default:             prdata = '0;
    endcase
  end

  // The whole pipeline advances together unless the output beat is held.
  logic ce, in_acc;
  logic out_v_q;
  logic signed [RV_W-1:0] out_rv_q;

  assign ce           = !out_v_q || out_o.ready;
  assign in_i.ready   = ce;
  assign in_acc       = in_i.valid && ce;
  assign out_o.valid  = out_v_q;
  assign out_o.radial_velocity = out_rv_q;

  // Valid bits, one per stage.
  logic [CS:0]   c_v_q;
  logic          p_v_q, d_v_q, s_v_q, m_v_q, v_v_q;
  logic [SQ_N:0] sq_v_q;
  logic [DV_N:0] dv_v_q;
  logic [S2_N:0] s2_v_q;
  logic [DC_N:0] dc_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q   <= '0;
      p_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      s_v_q   <= 1'b0;
      sq_v_q  <= '0;
      m_v_q   <= 1'b0;
      dv_v_q  <= '0;
      s2_v_q  <= '0;
      v_v_q   <= 1'b0;
      dc_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (ce) begin
      c_v_q   <= {c_v_q[CS-1:0], in_acc};
      p_v_q   <= c_v_q[CS];
      d_v_q   <= p_v_q;
      s_v_q   <= d_v_q;
      sq_v_q  <= {sq_v_q[SQ_N-1:0], s_v_q};
      m_v_q   <= sq_v_q[SQ_N];
      dv_v_q  <= {dv_v_q[DV_N-1:0], m_v_q};
      s2_v_q  <= {s2_v_q[S2_N-1:0], dv_v_q[DV_N]};
      v_v_q   <= s2_v_q[S2_N];
      dc_v_q  <= {dc_v_q[DC_N-1:0], v_v_q};
      out_v_q <= dc_v_q[DC_N];
    end
  end

  // Entry: fold both angles into the CORDIC range and flag points that give
  // zero (off the grid or a gate at the radar).
  ang_t  ang_b, ang_c;
  cord_t c_init;

  assign ang_b = prep_angle({in_i.azimuth_deg, 4'b0000});
  assign ang_c = prep_angle(ca_q);

  always_comb begin
    c_init.xb   = CORDIC_GAIN_Q30;
    c_init.yb   = '0;
    c_init.zb   = ang_b.z;
    c_init.flb  = ang_b.flip;
    c_init.xc   = CORDIC_GAIN_Q30;
    c_init.yc   = '0;
    c_init.zc   = ang_c.z;
    c_init.flc  = ang_c.flip;
    c_init.rk   = in_i.range_km;
    c_init.zero = (32'(in_i.azimuth_deg) >= AZIMUTH_STEPS) ||
                  (32'(in_i.range_km) >= RANGE_GATES) || (in_i.range_km == '0);
  end

  // CORDIC: one rotation per stage for the beam and the center in parallel.
  cord_t c_q [CS+1];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      c_q[0] <= c_init;
      for (int k = 0; k < CS; k++) begin
        c_q[k+1] <= cordic_iter(c_q[k], k);
      end
    end
  end

  // Positions in 2^-20 km: sine and cosine times range, floored.
  cord_t              cl;
  logic signed [32:0] sb, cb, sc, cc;
  logic signed [13:0] rk16_s, cr_s;
  logic signed [46:0] pxb, pyb, pxc, pyc;
  logic signed [31:0] p_xb_q, p_yb_q, p_xc_q, p_yc_q;
  side_t              p_sd_q, p_sd_d;

  assign cl = c_q[CS];

  always_comb begin
    sb     = cl.flb ? -cl.yb : cl.yb;
    cb     = cl.flb ? -cl.xb : cl.xb;
    sc     = cl.flc ? -cl.yc : cl.yc;
    cc     = cl.flc ? -cl.xc : cl.xc;
    rk16_s = $signed({1'b0, cl.rk, 4'b0000});
    cr_s   = $signed({1'b0, cr_q});
    pxb    = sb * rk16_s;
    pyb    = cb * rk16_s;
    pxc    = sc * cr_s;
    pyc    = cc * cr_s;
    p_sd_d.rk      = cl.rk;
    p_sd_d.zero    = cl.zero;
    p_sd_d.neg     = 1'b0;
    p_sd_d.in_core = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      p_xb_q <= pxb[45:14];
      p_yb_q <= pyb[45:14];
      p_xc_q <= pxc[45:14];
      p_yc_q <= pyc[45:14];
      p_sd_q <= p_sd_d;
    end
  end

  // Offset from the vortex center.
  logic signed [31:0] d_dx_q, d_dy_q, d_x_q, d_y_q;
  side_t              d_sd_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      d_dx_q <= p_xb_q - p_xc_q;
      d_dy_q <= p_yb_q - p_yc_q;
      d_x_q  <= p_xb_q;
      d_y_q  <= p_yb_q;
      d_sd_q <= p_sd_q;
    end
  end

  // Squares and the two terms of the cross product.
  logic signed [63:0] dxx, dyy, dxy, dyx;
  logic [61:0]        s_dxx_q, s_dyy_q;
  logic signed [63:0] s_cxy_q, s_cyx_q;
  side_t              s_sd_q;

  always_comb begin
    dxx = d_dx_q * d_dx_q;
    dyy = d_dy_q * d_dy_q;
    dxy = d_dx_q * d_y_q;
    dyx = d_dy_q * d_x_q;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s_dxx_q <= dxx[61:0];
      s_dyy_q <= dyy[61:0];
      s_cxy_q <= dxy;
      s_cyx_q <= dyx;
      s_sd_q  <= d_sd_q;
    end
  end

  // Distance: bit-pair square root, one result bit per stage. The first
  // stage also forms the cross product magnitude and its sign.
  function automatic sq62_t sq62_step(sq62_t s, int unsigned sh);
    logic [61:0] b;
    logic [61:0] t;
    sq62_t       o;
    b = 62'd1 << sh;
    t = s.res + b;
    if (s.num >= t) begin
      o.num = s.num - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.num = s.num;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  logic signed [63:0] cprod;
  logic [63:0]        cprod_abs;
  sq62_t              sq_init;
  side_t              sq_sd_init;
  sq62_t              sq_q    [SQ_N+1];
  logic [61:0]        sq_mag_q[SQ_N+1];
  side_t              sq_sd_q [SQ_N+1];

  always_comb begin
    cprod       = s_cxy_q - s_cyx_q;
    cprod_abs   = cprod[63] ? 64'(-cprod) : 64'(cprod);
    sq_init.num = s_dxx_q + s_dyy_q;
    sq_init.res = '0;
    sq_sd_init     = s_sd_q;
    sq_sd_init.neg = cprod[63];
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sq_q[0]     <= sq_init;
      sq_mag_q[0] <= cprod_abs[61:0];
      sq_sd_q[0]  <= sq_sd_init;
      for (int k = 0; k < SQ_N; k++) begin
        sq_q[k+1]     <= sq62_step(sq_q[k], 60 - 2*k);
        sq_mag_q[k+1] <= sq_mag_q[k];
        sq_sd_q[k+1]  <= sq_sd_q[k];
      end
    end
  end

  // Core test and V*r for the linear branch.
  logic [30:0] r_w;
  logic [28:0] rr_w;
  logic [23:0] vm_w;
  logic [54:0] vmr;
  side_t       m_sd_d, m_sd_q;
  logic [30:0] m_r_q;
  logic [54:0] m_vmr_q;
  logic [61:0] m_mag_q;

  assign r_w  = sq_q[SQ_N].res[30:0];
  assign rr_w = {mwr_q, 16'h0000};
  assign vm_w = {mws_q, 16'h0000};

  always_comb begin
    vmr    = vm_w * r_w;
    m_sd_d = sq_sd_q[SQ_N];
    m_sd_d.zero    = sq_sd_q[SQ_N].zero || (r_w == '0);
    m_sd_d.in_core = (29'(r_w) < rr_w) && (r_w[30:29] == 2'b00);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      m_r_q   <= r_w;
      m_vmr_q <= vmr;
      m_mag_q <= sq_mag_q[SQ_N];
      m_sd_q  <= m_sd_d;
    end
  end

  // Two restoring dividers side by side, one quotient bit per stage.
  // Lane a: V*r/R inside the core, or R*2^32/r outside. Lane b: |cross|/r.
  function automatic dvab_t dv_step(dvab_t s, int unsigned b);
    logic [63:0] sh;
    dvab_t       o;
    o  = s;
    sh = 64'(s.den_a) << b;
    if (s.rem_a >= sh) begin
      o.rem_a = s.rem_a - sh;
      o.q_a   = s.q_a | (33'd1 << b);
    end
    sh = 64'(s.den_b) << b;
    if (s.rem_b >= sh) begin
      o.rem_b = s.rem_b - sh;
      o.q_b   = s.q_b | (33'd1 << b);
    end
    return o;
  endfunction

  dvab_t dv_init;
  dvab_t dv_q   [DV_N+1];
  side_t dv_sd_q[DV_N+1];

  always_comb begin
    dv_init.rem_a = m_sd_q.in_core ? 64'(m_vmr_q) : {3'b000, mwr_q, 48'h0};
    dv_init.den_a = m_sd_q.in_core ? 31'(rr_w) : m_r_q;
    dv_init.q_a   = '0;
    dv_init.rem_b = 64'(m_mag_q);
    dv_init.den_b = m_r_q;
    dv_init.q_b   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      dv_q[0]    <= dv_init;
      dv_sd_q[0] <= m_sd_q;
      for (int k = 0; k < DV_N; k++) begin
        dv_q[k+1]    <= dv_step(dv_q[k], DV_N - 1 - k);
        dv_sd_q[k+1] <= dv_sd_q[k];
      end
    end
  end

  // Square root of R*2^32/r for the decaying branch.
  function automatic sq34_t sq34_step(sq34_t s, int unsigned sh);
    logic [33:0] b;
    logic [33:0] t;
    sq34_t       o;
    b = 34'd1 << sh;
    t = s.res + b;
    if (s.num >= t) begin
      o.num = s.num - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.num = s.num;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  sq34_t       s2_init;
  sq34_t       s2_q   [S2_N+1];
  logic [32:0] s2_qa_q[S2_N+1];
  logic [31:0] s2_t_q [S2_N+1];
  side_t       s2_sd_q[S2_N+1];

  always_comb begin
    s2_init.num = {1'b0, dv_q[DV_N].q_a};
    s2_init.res = '0;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s2_q[0]    <= s2_init;
      s2_qa_q[0] <= dv_q[DV_N].q_a;
      s2_t_q[0]  <= dv_q[DV_N].q_b[31:0];
      s2_sd_q[0] <= dv_sd_q[DV_N];
      for (int k = 0; k < S2_N; k++) begin
        s2_q[k+1]    <= sq34_step(s2_q[k], 32 - 2*k);
        s2_qa_q[k+1] <= s2_qa_q[k];
        s2_t_q[k+1]  <= s2_t_q[k];
        s2_sd_q[k+1] <= s2_sd_q[k];
      end
    end
  end

  // Tangential wind in 2^-16 m/s.
  logic [40:0] vsq;
  logic [23:0] v_vt_q;
  logic [31:0] v_t_q;
  side_t       v_sd_q;

  assign vsq = vm_w * s2_q[S2_N].res[16:0];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      v_vt_q <= s2_sd_q[S2_N].in_core ? s2_qa_q[S2_N][23:0] : vsq[39:16];
      v_t_q  <= s2_t_q[S2_N];
      v_sd_q <= s2_sd_q[S2_N];
    end
  end

  // Projection: (t*vt) >> 20 divided by the gate range in km, which equals
  // t*vt over the beam length in 2^-20 km.
  function automatic divc_t dc_step(divc_t s, logic [RK_W-1:0] den, int unsigned b);
    logic [44:0] sh;
    divc_t       o;
    o  = s;
    sh = 45'(den) << b;
    if (45'(s.rem) >= sh) begin
      o.rem = s.rem - sh[35:0];
      o.q   = s.q | (36'd1 << b);
    end
    return o;
  endfunction

  logic [55:0] tv;
  divc_t       dc_init;
  divc_t       dc_q   [DC_N+1];
  side_t       dc_sd_q[DC_N+1];

  always_comb begin
    tv          = v_t_q * v_vt_q;
    dc_init.rem = tv[55:20];
    dc_init.q   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      dc_q[0]    <= dc_init;
      dc_sd_q[0] <= v_sd_q;
      for (int k = 0; k < DC_N; k++) begin
        dc_q[k+1]    <= dc_step(dc_q[k], dc_sd_q[k].rk, DC_N - 1 - k);
        dc_sd_q[k+1] <= dc_sd_q[k];
      end
    end
  end

  // Round half up to 1/256 m/s, apply the sign and saturate.
  logic [36:0]            rnd;
  logic [28:0]            mq;
  logic [RV_W-1:0]        mag_neg;
  logic [RV_W-1:0]        mag_pos;
  logic signed [RV_W-1:0] rv_d;

  always_comb begin
    rnd     = {1'b0, dc_q[DC_N].q} + 37'd128;
    mq      = rnd[36:8];
    mag_neg = (mq >= 29'd65536) ? 17'h10000 : mq[16:0];
    mag_pos = (mq >= 29'd65535) ? 17'h0FFFF : mq[16:0];
    if (dc_sd_q[DC_N].zero) begin
      rv_d = '0;
    end else if (dc_sd_q[DC_N].neg) begin
      rv_d = $signed(-mag_neg);
    end else begin
      rv_d = $signed(mag_pos);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_rv_q <= rv_d;
    end
  end

  `RVRV_ASSERT(a_stall_freezes, clk_i, rst_ni, !ce |=> $stable(dc_v_q))
  `RVRV_ASSERT(a_zero_result, clk_i, rst_ni, (ce && dc_v_q[DC_N] && dc_sd_q[DC_N].zero) |=> (out_o.radial_velocity == '0))
  `RVRV_ASSERT(a_div_ab_rem, clk_i, rst_ni, (dv_v_q[DV_N] && !dv_sd_q[DV_N].zero) |-> (dv_q[DV_N].rem_a < 64'(dv_q[DV_N].den_a)))
  `RVRV_ASSERT(a_div_c_rem, clk_i, rst_ni, (dc_v_q[DC_N] && !dc_sd_q[DC_N].zero) |-> (dc_q[DC_N].rem < 36'(dc_sd_q[DC_N].rk)))

endmodule
